>>> rtl/core/threshold_area_time_integrator_defines.svh
// assertion macros for the threshold area and time integrator
`ifndef THRESHOLD_AREA_TIME_INTEGRATOR_DEFINES_SVH
`define THRESHOLD_AREA_TIME_INTEGRATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TATI_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define TATI_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/tati_pkg.sv
// shared widths, sequencer states and control bundle for the area and time integrator
package tati_pkg;

	localparam int unsigned VAL_W      = 32;
	localparam int unsigned AREA_W     = 64;
	localparam int unsigned IN_DATA_W  = 2 * VAL_W;
	localparam int unsigned OUT_DATA_W = AREA_W + VAL_W;
	localparam int unsigned DIV_STEPS  = VAL_W;
	localparam int unsigned CNT_W      = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_MUL,
		ST_DIV,
		ST_ACC
	} tati_state_t;

	typedef struct packed {
		logic in_ready;
		logic do_setup;
		logic do_mul;
		logic do_div;
		logic do_acc;
	} tati_ctrl_t;

endpackage

>>> rtl/core/threshold_area_time_integrator.sv
// threshold area and time integrator: one shared multiplier and a radix-2 divider under a sequencer
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid / tready        tdata = sample_time, sample_level; tlast = last_sample
//  m_axis    out  tvalid / tready        tdata = area_above, time_above; tuser = saturated
//  cfg       in   cfg_we (no wait)       cfg_wdata = threshold_level
//
//  a segment with a threshold crossing holds tready low after acceptance through setup,
//  one multiply, 32 divider steps, one multiply and the accumulate step
//  other samples hold it low through setup, one multiply and the accumulate step
//  the radix-2 divider loop is the longest part of a transaction
//  reset clears the threshold, the running totals and the output valid flag at once
//  the final sample of a curve waits in the accumulate step while an earlier result is unread
`include "threshold_area_time_integrator_defines.svh"

module threshold_area_time_integrator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tati_pkg::VAL_W-1:0]          cfg_wdata,      // threshold_level
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [tati_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // sample_time, sample_level
	input  logic                                s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [tati_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // area_above, time_above
	output logic                                m_axis_tuser    // saturated
);
	import tati_pkg::*;

	tati_state_t state_q, state_d;
	tati_ctrl_t  ctrl;

	logic [VAL_W-1:0]  thr_q;
	logic [VAL_W-1:0]  prev_level_q, prev_time_q;
	logic              first_q;
	logic [AREA_W-1:0] area_q;
	logic [VAL_W-1:0]  time_q;
	logic              clip_q;

	logic [VAL_W-1:0]  t_q, lv_q;
	logic              last_q;

	logic [VAL_W-1:0]  mul_a_q, mul_b_q, h_q, den_q, corr_q, tterm_q;
	logic              need_div_q, shr_q;
	logic [AREA_W-1:0] prod_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              out_valid_q, out_sat_q;
	logic [AREA_W-1:0] out_area_q;
	logic [VAL_W-1:0]  out_time_q;
	logic              out_free;

	// setup decode
	logic              above, equal, p_above, p_below;
	logic [VAL_W-1:0]  dt, lv_m, p_m, lv_p, p_lv;
	logic [VAL_W:0]    sum_h;
	logic [VAL_W-1:0]  set_a, set_b, set_h, set_den, set_corr, set_tterm;
	logic              set_div, set_shr;

	// divider step
	logic [VAL_W:0]    trial;
	logic              ge;
	logic [VAL_W:0]    trial_sub;
	logic [VAL_W-1:0]  rem_n;
	logic [AREA_W-1:0] div_n;

	// accumulate
	logic [AREA_W-1:0] aterm;
	logic [AREA_W:0]   asum;
	logic [VAL_W:0]    tsum;
	logic [AREA_W-1:0] area_n;
	logic [VAL_W-1:0]  time_n;
	logic              clip_n;

	assign out_free = !out_valid_q || m_axis_tready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (s_axis_tvalid) state_d = ST_SETUP;
			ST_SETUP: state_d = ST_MUL;
			ST_MUL:   state_d = need_div_q ? ST_DIV : ST_ACC;
			ST_DIV:   if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = ST_MUL;
			ST_ACC:   if (!last_q || out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_IDLE:  ctrl.in_ready = 1'b1;
			ST_SETUP: ctrl.do_setup = 1'b1;
			ST_MUL:   ctrl.do_mul   = 1'b1;
			ST_DIV:   ctrl.do_div   = 1'b1;
			ST_ACC:   ctrl.do_acc   = !last_q || out_free;
			default:  ctrl = '0;
		endcase
	end

	assign s_axis_tready = ctrl.in_ready;

	// segment classification against the threshold
	always_comb begin
		above   = lv_q > thr_q;
		equal   = lv_q == thr_q;
		p_above = prev_level_q > thr_q;
		p_below = prev_level_q < thr_q;
		dt      = (t_q >= prev_time_q) ? (t_q - prev_time_q) : '0;
		lv_m    = lv_q - thr_q;
		p_m     = prev_level_q - thr_q;
		lv_p    = lv_q - prev_level_q;
		p_lv    = prev_level_q - lv_q;
		sum_h   = {1'b0, p_m} + {1'b0, lv_m};

		set_a     = '0;
		set_b     = '0;
		set_h     = '0;
		set_den   = '0;
		set_corr  = '0;
		set_tterm = '0;
		set_div   = 1'b0;
		set_shr   = 1'b0;
		if (first_q) begin
			set_tterm = above ? t_q : '0;
		end else if (above && p_below) begin
			// rising crossing: triangle after the interpolated crossing
			set_a   = dt;
			set_b   = lv_m;
			set_den = lv_p;
			set_h   = lv_m;
			set_div = 1'b1;
			set_shr = 1'b1;
		end else if (above) begin
			// trapezoid, odd height sum adds half the base
			set_a     = sum_h[VAL_W:1];
			set_b     = dt;
			set_corr  = sum_h[0] ? (dt >> 1) : '0;
			set_tterm = dt;
		end else if (equal && p_above) begin
			// falling onto the threshold: full span and a triangle
			set_a     = p_m;
			set_b     = dt;
			set_shr   = 1'b1;
			set_tterm = dt;
		end else if (!equal && p_above) begin
			// falling crossing: triangle before the interpolated crossing
			set_a   = dt;
			set_b   = p_m;
			set_den = p_lv;
			set_h   = p_m;
			set_div = 1'b1;
			set_shr = 1'b1;
		end
	end

	// one restoring divider step over the product register
	always_comb begin
		trial     = {prod_q[AREA_W-1:VAL_W], prod_q[VAL_W-1]};
		ge        = trial >= {1'b0, den_q};
		trial_sub = trial - {1'b0, den_q};
		rem_n     = ge ? trial_sub[VAL_W-1:0] : trial[VAL_W-1:0];
		div_n     = {rem_n, prod_q[VAL_W-2:0], ge};
	end

	// saturating totals
	always_comb begin
		aterm  = shr_q ? {1'b0, prod_q[AREA_W-1:1]} : (prod_q + {{VAL_W{1'b0}}, corr_q});
		asum   = {1'b0, area_q} + {1'b0, aterm};
		tsum   = {1'b0, time_q} + {1'b0, tterm_q};
		area_n = asum[AREA_W] ? '1 : asum[AREA_W-1:0];
		clip_n = clip_q | asum[AREA_W];
		time_n = tsum[VAL_W] ? '1 : tsum[VAL_W-1:0];
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (ctrl.in_ready && s_axis_tvalid) begin
			t_q    <= s_axis_tdata[VAL_W-1:0];
			lv_q   <= s_axis_tdata[IN_DATA_W-1:VAL_W];
			last_q <= s_axis_tlast;
		end
	end

	// shared multiplier operands, divider and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_div_q <= 1'b0;
			cnt_q      <= '0;
		end else if (ctrl.do_setup) begin
			need_div_q <= set_div;
			cnt_q      <= '0;
		end else if (ctrl.do_div) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
				need_div_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.do_setup) begin
			mul_a_q <= set_a;
			mul_b_q <= set_b;
			h_q     <= set_h;
			den_q   <= set_den;
			corr_q  <= set_corr;
			tterm_q <= set_tterm;
			shr_q   <= set_shr;
		end else if (ctrl.do_mul) begin
			prod_q <= AREA_W'(mul_a_q) * AREA_W'(mul_b_q);
		end else if (ctrl.do_div) begin
			prod_q <= div_n;
			if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
				// crossing span drives both the time and the triangle base
				mul_a_q <= div_n[VAL_W-1:0];
				mul_b_q <= h_q;
				tterm_q <= div_n[VAL_W-1:0];
			end
		end
	end

	// curve state and running totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q <= '0;
			prev_time_q  <= '0;
			first_q      <= 1'b1;
			area_q       <= '0;
			time_q       <= '0;
			clip_q       <= 1'b0;
		end else if (ctrl.do_acc) begin
			if (last_q) begin
				prev_level_q <= '0;
				prev_time_q  <= '0;
				first_q      <= 1'b1;
				area_q       <= '0;
				time_q       <= '0;
				clip_q       <= 1'b0;
			end else begin
				prev_level_q <= lv_q;
				prev_time_q  <= t_q;
				first_q      <= 1'b0;
				area_q       <= area_n;
				time_q       <= time_n;
				clip_q       <= clip_n;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.do_acc && last_q) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.do_acc && last_q) begin
			out_area_q <= area_n;
			out_time_q <= time_n;
			out_sat_q  <= clip_n;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_time_q, out_area_q};
	assign m_axis_tuser  = out_sat_q;

	// checks
	`TATI_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while a sample is in flight")
	`TATI_ASSERT_IMPL(a_div_nonzero, clk, arst_n, state_q == ST_DIV, den_q != '0, "divider running on a zero level span")
	`TATI_ASSERT_IMPL(a_sat_all_ones, clk, arst_n, m_axis_tvalid && m_axis_tuser, &m_axis_tdata[AREA_W-1:0], "saturated result without a full area")

endmodule
